FILE: rtl/pcbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcbp_pkg;

  // fixed field widths
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned CODE_W  = 32;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned PAD_W   = 4;
  localparam int unsigned BYTE_W  = 8;

  // accumulator: up to 7 pending bits plus one full code word
  localparam int unsigned ACC_W   = CODE_W + BYTE_W - 1;
  localparam int unsigned TOTAL_W = 6;

  // input operation codes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_e;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_DATA  = 2'd0,
    KIND_FINAL = 2'd1,
    KIND_MISS  = 2'd2
  } kind_e;

  // commands handed from the front end to the packer
  typedef enum logic [1:0] {
    CMD_ENCODE = 2'd0,
    CMD_MISS   = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/prefix_code_bit_packer.sv
`timescale 1ns / 1ps
`default_nettype none

// Prefix code bit packer: back end of a Huffman encoder.
// Input channel (in_valid_i / in_ready_o) carries op, symbol, code word and
// length. A load writes one code table entry and gives no result. An encode
// appends the symbol's code to the bit accumulator and emits each finished
// byte, first code bit in the MSB; a symbol with no loaded code gives one
// miss result. A flush emits one final byte, zero padded, and empties the
// accumulator. Results leave on out_valid_o / out_ready_i, last marking the
// final result of each item.
// A flush or miss result passes the stage one register, the command queue and
// the output register; an encode's bytes also pass the bit accumulator.
// Throughput: the packer emits one byte per cycle while the receiver is
// ready, so an encode holds it until its last byte leaves; a flush or miss
// after an encode that emits bytes waits until that last byte has left.
// Reset clears the table valid marks and the accumulator; no clearing pass.
// When the receiver stalls, the output register holds its result, the
// command queue fills, and then in_ready_o drops.
module prefix_code_bit_packer #(
  parameter int unsigned MAX_CODE_LEN = 32,
  parameter int unsigned SYMBOL_COUNT = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [pcbp_pkg::OP_W-1:0]     op_i,
  input  wire logic [pcbp_pkg::SYM_W-1:0]    symbol_i,
  input  wire logic [pcbp_pkg::CODE_W-1:0]   code_word_i,
  input  wire logic [pcbp_pkg::LEN_W-1:0]    code_length_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [pcbp_pkg::BYTE_W-1:0]        out_byte_o,
  output logic [pcbp_pkg::KIND_W-1:0]        kind_o,
  output logic [pcbp_pkg::PAD_W-1:0]         pad_bits_o,
  output logic                               last_o
);

  import pcbp_pkg::*;

  localparam int unsigned LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  logic push;
  logic full;
  logic q_valid;
  logic q_pop;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  // table lookup and classification
  pcbp_front #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .LEN_CAP      (LEN_CAP)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .symbol_i      (symbol_i),
    .code_word_i   (code_word_i),
    .code_length_i (code_length_i),
    .push_o        (push),
    .cmd_o         (push_cmd),
    .full_i        (full)
  );

  // command queue between the two halves
  pcbp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .rdata_o (pop_cmd)
  );

  // bit packer and output register
  pcbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .cmd_i       (pop_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .kind_o      (kind_o),
    .pad_bits_o  (pad_bits_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

FILE: rtl/pcbp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pcbp_ram #(
  parameter int unsigned WIDTH = 38,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pcbp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pcbp_front #(
  parameter int unsigned SYMBOL_COUNT = 256,
  parameter int unsigned LEN_CAP      = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [pcbp_pkg::OP_W-1:0]     op_i,
  input  wire logic [pcbp_pkg::SYM_W-1:0]    symbol_i,
  input  wire logic [pcbp_pkg::CODE_W-1:0]   code_word_i,
  input  wire logic [pcbp_pkg::LEN_W-1:0]    code_length_i,
  output logic                               push_o,
  output pcbp_pkg::cmd_t                     cmd_o,
  input  wire logic                          full_i
);

  import pcbp_pkg::*;

  localparam int unsigned AW      = $clog2(SYMBOL_COUNT);
  localparam int unsigned ENTRY_W = CODE_W + LEN_W;

  op_e                 op;
  logic                accept;
  logic                advance;
  logic                take;
  logic                in_range;
  logic [AW-1:0]       addr;
  logic [LEN_W-1:0]    len_c;
  logic [CODE_W:0]     mask_ext;
  logic [CODE_W-1:0]   code_m;
  logic                ram_we;
  logic                ram_re;
  logic [ENTRY_W-1:0]  ram_rdata;

  logic [SYMBOL_COUNT-1:0] valid_q;
  logic                    s1_valid_q;
  logic                    s1_flush_q;
  logic                    s1_hit_q;
  logic [SYM_W-1:0]        s1_sym_q;

  assign op       = op_e'(op_i);
  assign in_range = {1'b0, symbol_i} < (SYM_W + 1)'(SYMBOL_COUNT);
  assign addr     = symbol_i[AW-1:0];
  assign take     = (op == OP_ENCODE) || (op == OP_FLUSH);

  // stage one moves whenever the queue can take what it holds
  assign advance    = !s1_valid_q || !full_i;
  assign in_ready_o = advance;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = s1_valid_q && !full_i;

  // load: saturate the length and drop bits above it
  assign len_c    = (code_length_i > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : code_length_i;
  assign mask_ext = ((CODE_W + 1)'(1) << len_c) - (CODE_W + 1)'(1);
  assign code_m   = code_word_i & mask_ext[CODE_W-1:0];

  assign ram_we = accept && (op == OP_LOAD) && in_range;
  assign ram_re = accept && (op == OP_ENCODE);

  pcbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr),
    .wdata_i ({len_c, code_m}),
    .re_i    (ram_re),
    .raddr_i (addr),
    .rdata_o (ram_rdata)
  );

  // entry valid marks and stage one control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (ram_we) begin
        valid_q[addr] <= 1'b1;
      end
      if (advance) begin
        s1_valid_q <= accept && take;
      end
    end
  end

  // stage one payload
  always_ff @(posedge clk_i) begin
    if (accept && take) begin
      s1_flush_q <= (op == OP_FLUSH);
      s1_sym_q   <= symbol_i;
      s1_hit_q   <= in_range && valid_q[addr];
    end
  end

  // classify into a packer command
  always_comb begin
    if (s1_flush_q) begin
      cmd_o.cmd = CMD_FLUSH;
    end else if (s1_hit_q) begin
      cmd_o.cmd = CMD_ENCODE;
    end else begin
      cmd_o.cmd = CMD_MISS;
    end
    cmd_o.sym  = s1_sym_q;
    cmd_o.code = ram_rdata[CODE_W-1:0];
    cmd_o.len  = ram_rdata[ENTRY_W-1:CODE_W];
  end

endmodule

`default_nettype wire

FILE: rtl/pcbp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module pcbp_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire pcbp_pkg::cmd_t wdata_i,
  output logic                full_o,
  output logic                valid_o,
  input  wire logic           pop_i,
  output pcbp_pkg::cmd_t      rdata_o
);

  import pcbp_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pcbp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pcbp_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_valid_i,
  output logic                               q_pop_o,
  input  wire pcbp_pkg::cmd_t                cmd_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [pcbp_pkg::BYTE_W-1:0]        out_byte_o,
  output logic [pcbp_pkg::KIND_W-1:0]        kind_o,
  output logic [pcbp_pkg::PAD_W-1:0]         pad_bits_o,
  output logic                               last_o
);

  import pcbp_pkg::*;

  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [TOTAL_W-1:0] pend_cnt;
  logic [ACC_W-1:0]   shifted;
  logic               slot_free;
  logic               busy;
  logic               emit;
  logic               emit_last;
  logic               is_enc;
  logic               can_pop;
  logic               load_out;
  logic [PAD_W-1:0]   pad;
  logic [BYTE_W-1:0]  out_byte_d;
  kind_e              kind_d;
  logic [PAD_W-1:0]   pad_d;
  logic               last_d;

  assign slot_free = !out_valid_o || out_ready_i;
  assign busy      = (total_q >= TOTAL_W'(BYTE_W));
  assign emit      = busy && slot_free;
  assign emit_last = total_q < TOTAL_W'(2 * BYTE_W);
  assign is_enc    = (cmd_i.cmd == CMD_ENCODE);

  // an encode may merge while the last byte of the previous one leaves
  assign can_pop = is_enc ? (!busy || (emit && emit_last)) : (!busy && slot_free);
  assign q_pop_o = q_valid_i && can_pop;
  assign load_out = emit || (q_pop_o && !is_enc);

  assign pend_cnt = emit ? (total_q - TOTAL_W'(BYTE_W)) : total_q;
  assign shifted  = acc_q >> (total_q - TOTAL_W'(BYTE_W));
  assign pad      = PAD_W'(BYTE_W) - {1'b0, total_q[2:0]};

  // accumulator update
  always_comb begin
    acc_d   = acc_q;
    total_d = pend_cnt;
    if (q_pop_o) begin
      case (cmd_i.cmd)
        CMD_ENCODE: begin
          acc_d   = (acc_q << cmd_i.len) | ACC_W'(cmd_i.code);
          total_d = pend_cnt + TOTAL_W'(cmd_i.len);
        end
        CMD_FLUSH: begin
          total_d = '0;
        end
        default: begin
          total_d = pend_cnt;
        end
      endcase
    end
  end

  // next result
  always_comb begin
    out_byte_d = shifted[BYTE_W-1:0];
    kind_d     = KIND_DATA;
    pad_d      = '0;
    last_d     = emit_last;
    if (!emit) begin
      case (cmd_i.cmd)
        CMD_FLUSH: begin
          out_byte_d = acc_q[BYTE_W-1:0] << pad;
          kind_d     = KIND_FINAL;
          pad_d      = pad;
          last_d     = 1'b1;
        end
        default: begin
          out_byte_d = cmd_i.sym;
          kind_d     = KIND_MISS;
          pad_d      = '0;
          last_d     = 1'b1;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      total_q     <= '0;
      out_valid_o <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      total_q <= total_d;
      if (slot_free) begin
        out_valid_o <= load_out;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (slot_free && load_out) begin
      out_byte_o <= out_byte_d;
      kind_o     <= kind_d;
      pad_bits_o <= pad_d;
      last_o     <= last_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pcbp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pcbp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_o,
  input wire logic [1:0] kind_o,
  input wire logic [3:0] pad_bits_o,
  input wire logic       last_o
);

  import pcbp_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(kind_o) && $stable(pad_bits_o) && $stable(last_o))
    else $error("stalled result changed");

  // final byte pads one to eight bits and closes its item
  a_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_FINAL |-> last_o && pad_bits_o != 4'd0
      && pad_bits_o <= 4'd8)
    else $error("bad final byte");

  // data and miss results carry no padding
  a_no_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_DATA || kind_o == KIND_MISS) |-> pad_bits_o == 4'd0)
    else $error("padding on data or miss");

  // a miss is always a single result
  a_miss_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_MISS |-> last_o)
    else $error("miss not last");

  // only defined kinds leave the block
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> kind_o != 2'd3)
    else $error("undefined result kind");

endmodule

bind prefix_code_bit_packer pcbp_checker u_pcbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o),
  .kind_o      (kind_o),
  .pad_bits_o  (pad_bits_o),
  .last_o      (last_o)
);

`default_nettype wire

FILE: dv/prefix_code_bit_packer_checker.sv
`timescale 1ns / 1ps

// watches both channels of the bit packer, predicts every result and
// compares it against what leaves the output channel
module prefix_code_bit_packer_checker
  import pcbp_pkg::*;
#(
  parameter int unsigned MAX_CODE_LEN = 32,
  parameter int unsigned SYMBOL_COUNT = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [OP_W-1:0]   op_i,
  input  logic [SYM_W-1:0]  symbol_i,
  input  logic [CODE_W-1:0] code_word_i,
  input  logic [LEN_W-1:0]  code_length_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [BYTE_W-1:0] out_byte_i,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [PAD_W-1:0]  pad_bits_i,
  input  logic              last_i,
  output int                fail_count_o,
  output int                results_waiting_o
);

  // longest code the table keeps, limited by the code word width
  localparam int unsigned LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  typedef struct {
    logic [BYTE_W-1:0] data;
    kind_e             kind;
    logic [PAD_W-1:0]  pad;
    logic              last;
  } packer_result_t;

  // shadow code table and bit accumulator
  logic [CODE_W-1:0] code_tbl  [SYMBOL_COUNT];
  logic [LEN_W-1:0]  len_tbl   [SYMBOL_COUNT];
  bit                has_entry [SYMBOL_COUNT];
  logic [6:0]        pend_bits;
  int unsigned       pend_count;

  packer_result_t    packed_result_q[$];

  // work out the results of one accepted item and update the shadow state
  task automatic pack_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] word, input logic [LEN_W-1:0] len);
    int unsigned    ln;
    int unsigned    total;
    int unsigned    nbytes;
    int unsigned    pad;
    logic [63:0]    acc;
    logic [15:0]    shifted;
    packer_result_t res;
    case (op)
      OP_LOAD: begin
        if (sym < SYMBOL_COUNT) begin
          ln = (len > LEN_CAP) ? LEN_CAP : len;
          code_tbl[sym]  = CODE_W'({32'd0, word} & ((64'd1 << ln) - 64'd1));
          len_tbl[sym]   = LEN_W'(ln);
          has_entry[sym] = 1'b1;
        end
      end
      OP_ENCODE: begin
        if (sym >= SYMBOL_COUNT || !has_entry[sym]) begin
          // symbol without code: report the symbol, accumulator untouched
          res.data = sym;
          res.kind = KIND_MISS;
          res.pad  = '0;
          res.last = 1'b1;
          packed_result_q = {packed_result_q, res};
        end else begin
          ln     = len_tbl[sym];
          acc    = ({57'd0, pend_bits} << ln) | {32'd0, code_tbl[sym]};
          total  = pend_count + ln;
          nbytes = total / BYTE_W;
          for (int i = 0; i < nbytes; i++) begin
            total    = total - BYTE_W;
            res.data = BYTE_W'(acc >> total);
            res.kind = KIND_DATA;
            res.pad  = '0;
            res.last = (i == nbytes - 1);
            packed_result_q = {packed_result_q, res};
          end
          pend_bits  = 7'(acc & ((64'd1 << total) - 64'd1));
          pend_count = total;
        end
      end
      OP_FLUSH: begin
        // leftover bits left-aligned, always one byte out
        pad      = BYTE_W - pend_count;
        shifted  = {9'd0, pend_bits} << pad;
        res.data = shifted[BYTE_W-1:0];
        res.kind = KIND_FINAL;
        res.pad  = PAD_W'(pad);
        res.last = 1'b1;
        packed_result_q = {packed_result_q, res};
        pend_bits  = '0;
        pend_count = 0;
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  // match one output item against the oldest prediction
  task automatic check_result();
    packer_result_t want;
    if (packed_result_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, got byte %0d kind %0d pad %0d last %0d",
               $time, out_byte_i, kind_i, pad_bits_i, last_i);
      fail_count_o++;
    end else begin
      want = packed_result_q.pop_front();
      compare_field("out_byte", want.data, out_byte_i);
      compare_field("kind", want.kind, kind_i);
      compare_field("pad_bits", want.pad, pad_bits_i);
      compare_field("last", want.last, last_i);
    end
  endtask

  // sample both channels at each rising edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      foreach (has_entry[i]) has_entry[i] = 1'b0;
      pend_bits  = '0;
      pend_count = 0;
      packed_result_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        pack_item(op_i, symbol_i, code_word_i, code_length_i);
      end
      if (out_valid_i && out_ready_i) begin
        check_result();
      end
    end
    results_waiting_o = packed_result_q.size();
  end

endmodule

FILE: dv/prefix_code_bit_packer_tb.sv
`timescale 1ns / 1ps

module prefix_code_bit_packer_tb;
  import pcbp_pkg::*;

  localparam int unsigned MAX_CODE_LEN = 32;
  localparam int unsigned SYMBOL_COUNT = 256;
  localparam int unsigned RANDOM_ITEMS = 300;
  localparam int unsigned HOLD_CYCLES  = 300;
  // op value the block ignores
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [OP_W-1:0]   op_i;
  logic [SYM_W-1:0]  symbol_i;
  logic [CODE_W-1:0] code_word_i;
  logic [LEN_W-1:0]  code_length_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [BYTE_W-1:0] out_byte_o;
  logic [KIND_W-1:0] kind_o;
  logic [PAD_W-1:0]  pad_bits_o;
  logic              last_o;

  int                fail_count;
  int                results_waiting;
  int                items_sent = 0;
  logic [SYM_W-1:0]  coded_syms[$];

  always #6 clk_i = ~clk_i;

  prefix_code_bit_packer #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .symbol_i      (symbol_i),
    .code_word_i   (code_word_i),
    .code_length_i (code_length_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .kind_o        (kind_o),
    .pad_bits_o    (pad_bits_o),
    .last_o        (last_o)
  );

  prefix_code_bit_packer_checker #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) pack_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .op_i              (op_i),
    .symbol_i          (symbol_i),
    .code_word_i       (code_word_i),
    .code_length_i     (code_length_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_byte_i        (out_byte_o),
    .kind_i            (kind_o),
    .pad_bits_i        (pad_bits_o),
    .last_i            (last_o),
    .fail_count_o      (fail_count),
    .results_waiting_o (results_waiting)
  );

  // idle length: mostly none or short, now and then long
  function automatic int idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // a window in the middle of the run with no idling on either side
  function automatic bit busy_window();
    return items_sent >= 200 && items_sent < 250;
  endfunction

  // offer one item and hold it until accepted
  task automatic send_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] word, input logic [LEN_W-1:0] len);
    int gap;
    in_valid_i    <= 1'b1;
    op_i          <= op;
    symbol_i      <= sym;
    code_word_i   <= word;
    code_length_i <= len;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    if (op == OP_LOAD) coded_syms.push_front(sym);
    gap = busy_window() ? 0 : idle_cycles();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [LEN_W-1:0] random_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return LEN_W'($urandom_range(1, 12));
    if (r < 90) return LEN_W'($urandom_range(13, 32));
    if (r < 95) return '0;
    return LEN_W'($urandom_range(33, 63));
  endfunction

  // one random item, mostly encodes of symbols that have a code
  task automatic send_random_item();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12 || (r < 80 && coded_syms.size() == 0)) begin
      send_item(OP_LOAD, SYM_W'($urandom_range(0, 255)), $urandom, random_length());
    end else if (r < 80) begin
      send_item(OP_ENCODE, coded_syms[$urandom_range(0, coded_syms.size() - 1)],
                $urandom, LEN_W'($urandom));
    end else if (r < 87) begin
      send_item(OP_ENCODE, SYM_W'($urandom_range(0, 255)), $urandom, LEN_W'($urandom));
    end else if (r < 95) begin
      send_item(OP_FLUSH, SYM_W'($urandom_range(0, 255)), $urandom, LEN_W'($urandom));
    end else begin
      send_item(OP_UNUSED, SYM_W'($urandom_range(0, 255)), $urandom, LEN_W'($urandom));
    end
  endtask

  // receiver: random stalls plus one long hold-off to back up the block
  initial begin
    int run;
    int stall;
    bit held;
    held = 1'b0;
    out_ready_i <= 1'b0;
    repeat (8) @(posedge clk_i);
    forever begin
      if (!held && items_sent >= 60) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      run = $urandom_range(1, 20);
      out_ready_i <= 1'b1;
      repeat (run) @(posedge clk_i);
      stall = busy_window() ? 0 : idle_cycles();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // stimulus and verdict
  initial begin
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    op_i          <= OP_LOAD;
    symbol_i      <= '0;
    code_word_i   <= '0;
    code_length_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // miss before any load, then flush of an empty accumulator
    send_item(OP_ENCODE, 8'h00, 32'h0, 6'd0);
    send_item(OP_FLUSH, 8'h00, 32'h0, 6'd0);
    // full-length code, overlong length, zero length, bits above length
    send_item(OP_LOAD, 8'hff, 32'hffff_ffff, 6'd32);
    send_item(OP_LOAD, 8'h00, 32'ha5a5_5a5a, 6'd63);
    send_item(OP_LOAD, 8'h01, 32'h1234_5678, 6'd0);
    send_item(OP_LOAD, 8'h02, 32'hffff_ffff, 6'd3);
    send_item(OP_LOAD, 8'h03, 32'h0000_0001, 6'd1);
    send_item(OP_LOAD, 8'h80, 32'h0000_0000, 6'd33);
    // encodes that give no byte, four bytes, and nothing at all
    send_item(OP_ENCODE, 8'h02, 32'h0, 6'd0);
    send_item(OP_ENCODE, 8'hff, 32'h0, 6'd0);
    send_item(OP_ENCODE, 8'h01, 32'h0, 6'd0);
    send_item(OP_ENCODE, 8'h00, 32'h0, 6'd0);
    send_item(OP_UNUSED, 8'h55, 32'hdead_beef, 6'd21);
    send_item(OP_ENCODE, 8'h03, 32'h0, 6'd0);
    send_item(OP_FLUSH, 8'h00, 32'h0, 6'd0);
    // miss on an unloaded symbol leaves pending bits alone
    send_item(OP_ENCODE, 8'h02, 32'h0, 6'd0);
    send_item(OP_ENCODE, 8'h7f, 32'h0, 6'd0);
    send_item(OP_FLUSH, 8'h00, 32'h0, 6'd0);
    send_item(OP_FLUSH, 8'h00, 32'h0, 6'd0);
    // seven pending bits flush with a single pad bit
    send_item(OP_LOAD, 8'h04, 32'h0000_007f, 6'd7);
    send_item(OP_ENCODE, 8'h04, 32'h0, 6'd0);
    send_item(OP_FLUSH, 8'h00, 32'h0, 6'd0);
    send_item(OP_ENCODE, 8'h80, 32'h0, 6'd0);
    send_item(OP_FLUSH, 8'h00, 32'h0, 6'd0);

    repeat (RANDOM_ITEMS) send_random_item();
    in_valid_i <= 1'b0;

    // drain and let the pipeline settle
    @(posedge clk_i);
    wait (results_waiting == 0);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/pcbp_pkg.sv
rtl/pcbp_ram.sv
rtl/pcbp_front.sv
rtl/pcbp_fifo.sv
rtl/pcbp_back.sv
rtl/prefix_code_bit_packer.sv
rtl/pcbp_checker.sv
dv/prefix_code_bit_packer_checker.sv
dv/prefix_code_bit_packer_tb.sv
